### hw/rtl/led_strip_gamma_pulse_encoder_unit_macros.svh
// Assertion macros for the LED strip pulse encoder.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef LED_STRIP_GAMMA_PULSE_ENCODER_UNIT_MACROS_SVH
`define LED_STRIP_GAMMA_PULSE_ENCODER_UNIT_MACROS_SVH

// Property that holds at every clock edge out of reset.
`define LSGPE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LSGPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lsgpe_pkg.sv
// Package for the LED strip pulse encoder: sizes, codes, shared structs
// and the gamma table. No dependencies.
`default_nettype none

package lsgpe_pkg;

  localparam int unsigned LED_COUNT    = 10;
  localparam int unsigned RESET_SLOTS  = 200;
  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned TICK_W       = 10;

  localparam int unsigned LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned BIT_W = $clog2(BITS_PER_LED);
  localparam int unsigned GAP_W = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;

  localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = TICK_W'(10);
  localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = TICK_W'(3);

  typedef enum logic {
    OP_SET_COLOR = 1'b0,
    OP_TICK      = 1'b1
  } op_e;

  typedef enum logic {
    CFG_ONE_HIGH  = 1'b0,
    CFG_ZERO_HIGH = 1'b1
  } cfg_reg_e;

  // Position of the current data slot.
  typedef struct packed {
    logic [LED_W-1:0] led;
    logic [BIT_W-1:0] bit_sel;
  } slot_pos_t;

  // Colour store write request (levels before gamma).
  typedef struct packed {
    logic             en;
    logic [LED_W-1:0] led;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [7:0]       blue;
  } color_wr_t;

  typedef logic [255:0][7:0] gamma_rom_t;

  // g(v) = largest k with k^5 * 255^6 <= v^11, evaluated at elaboration.
  function automatic gamma_rom_t build_gamma();
    gamma_rom_t   rom;
    logic [127:0] scale;
    logic [127:0] lhs;
    logic [127:0] rhs;
    int unsigned  k;
    logic         done;
    rom   = '0;
    scale = 128'd1;
    for (int i = 0; i < 6; i++) begin
      scale = scale * 128'd255;
    end
    k = 0;
    for (int v = 0; v < 256; v++) begin
      rhs = 128'd1;
      for (int j = 0; j < 11; j++) begin
        rhs = rhs * 128'(v);
      end
      done = 1'b0;
      while (k < 255 && !done) begin
        lhs = scale;
        for (int j = 0; j < 5; j++) begin
          lhs = lhs * 128'(k + 1);
        end
        if (lhs > rhs) begin
          done = 1'b1;
        end else begin
          k = k + 1;
        end
      end
      rom[v] = 8'(k);
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

`default_nettype wire

### hw/rtl/led_strip_gamma_pulse_encoder_unit.sv
// Top level of the LED strip pulse encoder: slot sequencer, timing
// registers and output register. Depends on lsgpe_pkg, lsgpe_color_store
// and the assertion macro header.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------
//   in      | sink      | in_valid_i / in_stall_o  | opcode, led_index, g/r/b levels
//   out     | source    | out_valid_o / out_stall_i| pulse_high_ticks, frame_last
//   cfg     | sink      | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One item per cycle unless the input stalls; each transfer is handled in the cycle it is taken.
// A tick's slot is loaded into the output register at its transfer edge and
// is offered from the next cycle on.
// A set-colour writes the store at its transfer edge; later ticks see it.
// Input stalls only while the output register is full and itself stalled.
// Reset clears the colour store and the slot position, and loads the timing
// registers with their default high times.
`default_nettype none

`include "led_strip_gamma_pulse_encoder_unit_macros.svh"

module led_strip_gamma_pulse_encoder_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [lsgpe_pkg::TICK_W-1:0]    cfg_wdata_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            opcode_i,
  input  wire logic [7:0]                      led_index_i,
  input  wire logic [7:0]                      green_level_i,
  input  wire logic [7:0]                      red_level_i,
  input  wire logic [7:0]                      blue_level_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [lsgpe_pkg::TICK_W-1:0]         pulse_high_ticks_o,
  output logic                                 frame_last_o
);

  localparam int unsigned LED_W = lsgpe_pkg::LED_W;
  localparam int unsigned BIT_W = lsgpe_pkg::BIT_W;
  localparam int unsigned GAP_W = lsgpe_pkg::GAP_W;

  localparam logic [LED_W-1:0] LED_LAST = LED_W'(lsgpe_pkg::LED_COUNT - 1);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(lsgpe_pkg::BITS_PER_LED - 1);
  localparam logic [GAP_W-1:0] GAP_LAST = GAP_W'(lsgpe_pkg::RESET_SLOTS - 1);

  // timing registers
  logic [lsgpe_pkg::TICK_W-1:0] one_high_q, zero_high_q;

  // slot position: data slots walk led/bit, then the reset gap counts up
  logic [LED_W-1:0] led_q, led_d;
  logic [BIT_W-1:0] bit_sel_q, bit_sel_d;
  logic [GAP_W-1:0] gap_q, gap_d;
  logic             in_gap_q, in_gap_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [lsgpe_pkg::TICK_W-1:0] pulse_q, pulse_d;
  logic                         last_q, last_d;

  logic                 in_xfer;
  logic                 tick_xfer;
  logic                 slot_last;
  logic                 data_bit;
  lsgpe_pkg::op_e       op;
  lsgpe_pkg::color_wr_t color_wr;
  lsgpe_pkg::slot_pos_t rd_pos;

  assign op         = lsgpe_pkg::op_e'(opcode_i);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    tick_xfer    = 1'b0;
    color_wr     = '0;
    color_wr.led = led_index_i[LED_W-1:0];
    color_wr.green = green_level_i;
    color_wr.red   = red_level_i;
    color_wr.blue  = blue_level_i;
    case (op)
      lsgpe_pkg::OP_SET_COLOR: begin
        // indexes at or past the LED count are dropped
        color_wr.en = in_xfer && (32'(led_index_i) < 32'(lsgpe_pkg::LED_COUNT));
      end
      lsgpe_pkg::OP_TICK: begin
        tick_xfer = in_xfer;
      end
      default: begin
        tick_xfer = 1'b0;
      end
    endcase
  end

  assign rd_pos.led     = led_q;
  assign rd_pos.bit_sel = bit_sel_q;

  lsgpe_color_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (color_wr),
    .rd_pos_i (rd_pos),
    .rd_bit_o (data_bit)
  );

  assign slot_last = in_gap_q && (gap_q == GAP_LAST);

  // next slot position
  always_comb begin
    led_d     = led_q;
    bit_sel_d = bit_sel_q;
    gap_d     = gap_q;
    in_gap_d  = in_gap_q;
    if (tick_xfer) begin
      if (in_gap_q) begin
        if (slot_last) begin
          in_gap_d  = 1'b0;
          led_d     = '0;
          bit_sel_d = '0;
          gap_d     = '0;
        end else begin
          gap_d = gap_q + GAP_W'(1);
        end
      end else if (bit_sel_q == BIT_LAST) begin
        bit_sel_d = '0;
        if (led_q == LED_LAST) begin
          in_gap_d = 1'b1;
          gap_d    = '0;
        end else begin
          led_d = led_q + LED_W'(1);
        end
      end else begin
        bit_sel_d = bit_sel_q + BIT_W'(1);
      end
    end
  end

  // output register with hold while stalled
  always_comb begin
    out_valid_d = out_valid_q;
    pulse_d     = pulse_q;
    last_d      = last_q;
    if (tick_xfer) begin
      out_valid_d = 1'b1;
      pulse_d     = in_gap_q ? '0 : (data_bit ? one_high_q : zero_high_q);
      last_d      = slot_last;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_high_q  <= lsgpe_pkg::ONE_HIGH_RESET;
      zero_high_q <= lsgpe_pkg::ZERO_HIGH_RESET;
      led_q       <= '0;
      bit_sel_q   <= '0;
      gap_q       <= '0;
      in_gap_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (lsgpe_pkg::cfg_reg_e'(cfg_idx_i))
          lsgpe_pkg::CFG_ONE_HIGH:  one_high_q  <= cfg_wdata_i;
          lsgpe_pkg::CFG_ZERO_HIGH: zero_high_q <= cfg_wdata_i;
          default: begin
            one_high_q <= one_high_q;
          end
        endcase
      end
      led_q       <= led_d;
      bit_sel_q   <= bit_sel_d;
      gap_q       <= gap_d;
      in_gap_q    <= in_gap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    pulse_q <= pulse_d;
    last_q  <= last_d;
  end

  assign out_valid_o        = out_valid_q;
  assign pulse_high_ticks_o = pulse_q;
  assign frame_last_o       = last_q;

  // assertions
  `LSGPE_ASSERT_ALWAYS(a_gap_pos_parked,
    !in_gap_q || (led_q == LED_LAST && bit_sel_q == '0),
    "led/bit position moved during reset gap")
  `LSGPE_ASSERT_ALWAYS(a_bit_in_range, in_gap_q || (bit_sel_q <= BIT_LAST),
    "bit select past last colour bit")
  `LSGPE_ASSERT_ALWAYS(a_last_is_gap,
    !(out_valid_o && frame_last_o) || (pulse_high_ticks_o == '0),
    "frame end slot carries a pulse")
  `LSGPE_ASSERT_ALWAYS(a_stall_needs_full, !in_stall_o || out_valid_o,
    "input stalled with empty output register")
  `LSGPE_ASSERT_NEXT(a_frame_wrap, tick_xfer && slot_last,
    !in_gap_q && led_q == '0 && bit_sel_q == '0,
    "position did not wrap after frame end")

endmodule

`default_nettype wire

### hw/rtl/lsgpe_color_store.sv
// Per-LED colour store: gamma-corrected GRB word per LED, cleared at reset.
// Depends on lsgpe_pkg.
`default_nettype none

module lsgpe_color_store (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lsgpe_pkg::color_wr_t  wr_i,
  input  wire lsgpe_pkg::slot_pos_t  rd_pos_i,
  output logic                       rd_bit_o
);

  localparam int unsigned WORD_W = lsgpe_pkg::BITS_PER_LED;

  logic [WORD_W-1:0] store_q [lsgpe_pkg::LED_COUNT];
  logic [lsgpe_pkg::BIT_W-1:0] bit_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(lsgpe_pkg::LED_COUNT); i++) begin
        store_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      store_q[wr_i.led] <= {lsgpe_pkg::GAMMA_ROM[wr_i.green],
                            lsgpe_pkg::GAMMA_ROM[wr_i.red],
                            lsgpe_pkg::GAMMA_ROM[wr_i.blue]};
    end
  end

  // green byte sits at the top, so MSB first is a count down from the top bit
  assign bit_idx  = lsgpe_pkg::BIT_W'(WORD_W - 1) - rd_pos_i.bit_sel;
  assign rd_bit_o = store_q[rd_pos_i.led][bit_idx];

endmodule

`default_nettype wire

### bench/led_strip_gamma_pulse_encoder_checker.sv
// Checker for the LED strip pulse encoder: watches the config port and both channels,
// predicts every slot and compares it with what the block emits.
// Depends on lsgpe_pkg for sizes and codes.
module led_strip_gamma_pulse_encoder_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [lsgpe_pkg::TICK_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        opcode_i,
  input  logic [7:0]                  led_index_i,
  input  logic [7:0]                  green_level_i,
  input  logic [7:0]                  red_level_i,
  input  logic [7:0]                  blue_level_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [lsgpe_pkg::TICK_W-1:0] pulse_high_ticks_i,
  input  logic                        frame_last_i,
  output logic [31:0]                 fail_count_o,
  output logic [31:0]                 pending_o,
  output logic [31:0]                 slots_checked_o,
  output logic [31:0]                 frames_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsgpe_pkg::*;

  localparam int unsigned DATA_SLOTS  = LED_COUNT * BITS_PER_LED;
  localparam int unsigned FRAME_SLOTS = DATA_SLOTS + RESET_SLOTS;

  typedef struct packed {
    logic [TICK_W-1:0] ticks;
    logic              last;
  } pulse_t;

  logic [7:0]        gamma_lut [256];
  logic [7:0]        colour_mem [LED_COUNT*3];
  int unsigned       slot_pos;
  logic [TICK_W-1:0] one_ticks;
  logic [TICK_W-1:0] zero_ticks;
  pulse_t            pending_pulses [$];
  pulse_t            want;
  int unsigned       mismatches     = 0;
  int unsigned       slots_checked  = 0;
  int unsigned       frames_checked = 0;

  assign fail_count_o     = mismatches;
  assign pending_o        = pending_pulses.size();
  assign slots_checked_o  = slots_checked;
  assign frames_checked_o = frames_checked;

  function automatic bit [127:0] ipow(input bit [127:0] base, input int n);
    bit [127:0] acc = 1;
    for (int i = 0; i < n; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // Gamma: largest k with k^5 * 255^6 <= v^11, found by bisection.
  initial begin
    bit [127:0] rhs;
    bit [127:0] scale;
    int         lo;
    int         hi;
    int         mid;
    scale = ipow(255, 6);
    for (int v = 0; v < 256; v++) begin
      rhs = ipow(v, 11);
      lo  = 0;
      hi  = 255;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (ipow(mid, 5) * scale <= rhs) lo = mid;
        else hi = mid - 1;
      end
      gamma_lut[v] = 8'(lo);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Next slot of the frame; colours are read live from the store.
  task automatic next_pulse(output pulse_t p);
    int unsigned bit_in_led;
    logic [7:0]  colour;
    p = '0;
    if (slot_pos < DATA_SLOTS) begin
      bit_in_led = slot_pos % BITS_PER_LED;
      colour     = colour_mem[(slot_pos / BITS_PER_LED) * 3 + bit_in_led / 8];
      p.ticks    = colour[7 - bit_in_led % 8] ? one_ticks : zero_ticks;
    end
    p.last   = (slot_pos == FRAME_SLOTS - 1);
    slot_pos = p.last ? 0 : slot_pos + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (colour_mem[i]) colour_mem[i] = '0;
      slot_pos   = 0;
      one_ticks  = ONE_HIGH_RESET;
      zero_ticks = ZERO_HIGH_RESET;
      pending_pulses.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ONE_HIGH) one_ticks = cfg_wdata_i;
        else zero_ticks = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_pulses.size() == 0) begin
          report_mismatch($sformatf("slot with nothing expected (ticks %0d last %0b)",
                                    pulse_high_ticks_i, frame_last_i));
        end else begin
          want = pending_pulses.pop_front();
          if (pulse_high_ticks_i !== want.ticks)
            report_mismatch($sformatf("slot %0d high ticks: expected %0d, got %0d",
                                      slots_checked, want.ticks, pulse_high_ticks_i));
          if (frame_last_i !== want.last)
            report_mismatch($sformatf("slot %0d frame end flag: expected %0b, got %0b",
                                      slots_checked, want.last, frame_last_i));
          if (want.last) frames_checked++;
          slots_checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_TICK) begin
          next_pulse(want);
          pending_pulses.push_back(want);
        end else if (led_index_i < LED_COUNT) begin
          colour_mem[led_index_i * 3]     = gamma_lut[green_level_i];
          colour_mem[led_index_i * 3 + 1] = gamma_lut[red_level_i];
          colour_mem[led_index_i * 3 + 2] = gamma_lut[blue_level_i];
        end
      end
    end
  end

endmodule

### bench/tb_led_strip_gamma_pulse_encoder_unit.sv
// Testbench top for the LED strip pulse encoder: clock, reset, stimulus and verdict.
// Depends on lsgpe_pkg, the encoder RTL and led_strip_gamma_pulse_encoder_checker.
module tb_led_strip_gamma_pulse_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lsgpe_pkg::*;

  localparam int unsigned ITEMS_TOTAL  = 2000;
  localparam int unsigned PHASES       = 6;    // reset timing plus five written settings
  localparam int unsigned DRAIN_CYCLES = 4;    // slot lands in the cycle after its transfer
  localparam int unsigned LONG_HOLD    = 150;  // cycles of forced output stall
  localparam int unsigned HOLD_ITEMS   = 80;   // back-to-back items offered around the hold
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef struct {
    op_e        op;
    logic [7:0] led;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } item_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_idx_i     = 1'b0;
  logic [TICK_W-1:0] cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              opcode_i      = 1'b0;
  logic [7:0]        led_index_i   = '0;
  logic [7:0]        green_level_i = '0;
  logic [7:0]        red_level_i   = '0;
  logic [7:0]        blue_level_i  = '0;
  logic              out_stall_i   = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [TICK_W-1:0] pulse_high_ticks_o;
  logic              frame_last_o;

  logic [31:0] fail_count;
  logic [31:0] pending;
  logic [31:0] slots_checked;
  logic [31:0] frames_checked;

  // Handshake between the stimulus and the output stall process.
  logic stall_en = 1'b1;
  logic hold_req = 1'b0;

  int unsigned cycles     = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_sets     = 0;
  int unsigned n_ignored  = 0;
  int unsigned n_settings = 1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  led_strip_gamma_pulse_encoder_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .led_index_i       (led_index_i),
    .green_level_i     (green_level_i),
    .red_level_i       (red_level_i),
    .blue_level_i      (blue_level_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pulse_high_ticks_o(pulse_high_ticks_o),
    .frame_last_o      (frame_last_o)
  );

  led_strip_gamma_pulse_encoder_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .opcode_i          (opcode_i),
    .led_index_i       (led_index_i),
    .green_level_i     (green_level_i),
    .red_level_i       (red_level_i),
    .blue_level_i      (blue_level_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pulse_high_ticks_i(pulse_high_ticks_o),
    .frame_last_i      (frame_last_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .slots_checked_o   (slots_checked),
    .frames_checked_o  (frames_checked)
  );

  // Watchdog: a hung handshake or a lost slot ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d slots still expected", cycles, pending);
      $display("tb_led_strip_gamma_pulse_encoder_unit failed");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Levels lean on the ends of the range so both gamma extremes show up often.
  function automatic logic [7:0] rand_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t mk(op_e op, logic [7:0] led, logic [7:0] g, logic [7:0] r,
                               logic [7:0] b);
    item_t it;
    it.op    = op;
    it.led   = led;
    it.green = g;
    it.red   = r;
    it.blue  = b;
    return it;
  endfunction

  // Output stall: random runs with calm stretches in between, plus one long hold
  // on request so the output register fills and the input channel backs up.
  initial begin
    int unsigned run_left   = 0;
    int unsigned spell_left = 0;
    int unsigned hold_left  = 0;
    bit          calm       = 1'b0;
    bit          hold_taken = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!stall_en) begin
        out_stall_i <= 1'b0;
      end else begin
        if (spell_left == 0) begin
          calm       = ($urandom_range(0, 3) == 0);
          spell_left = $urandom_range(20, 80);
        end
        spell_left--;
        if (run_left > 0) begin
          out_stall_i <= 1'b1;
          run_left--;
        end else begin
          out_stall_i <= 1'b0;
          if (!calm) run_left = gap_len();
        end
      end
    end
  end

  task automatic idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Offer one item and hold it steady until the transfer happens.
  task automatic push_item(input item_t it);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    opcode_i      <= it.op;
    led_index_i   <= it.led;
    green_level_i <= it.green;
    red_level_i   <= it.red;
    blue_level_i  <= it.blue;
    do @(posedge clk_i); while (in_stall_o);
    if (it.op == OP_TICK) n_ticks++;
    else if (it.led < LED_COUNT) n_sets++;
    else n_ignored++;
  endtask

  // Wait until every slot has come out and the last colour write has settled.
  task automatic settle(input bit quiet_out);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    if (quiet_out) stall_en <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [TICK_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random traffic: roughly two ticks per colour write so frames wrap several
  // times; out-of-range writes are extra and not counted. With the hold on,
  // the first items go back to back so the sender keeps pushing into a full block.
  task automatic run_random(input int unsigned n, input bit with_hold);
    item_t       it;
    int unsigned counted    = 0;
    int unsigned burst_left = 0;
    bit          burst      = 1'b0;
    if (with_hold) begin
      @(negedge clk_i);
      hold_req <= 1'b1;
    end
    while (counted < n) begin
      if ($urandom_range(0, 99) < 65) begin
        it = mk(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        it = mk(OP_SET_COLOR,
                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, LED_COUNT - 1)),
                rand_level(), rand_level(), rand_level());
      end
      if (burst_left == 0) begin
        burst      = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(10, 50);
      end
      burst_left--;
      if (!(burst || (with_hold && counted < HOLD_ITEMS))) idle(gap_len());
      push_item(it);
      if (!(it.op == OP_SET_COLOR && it.led >= LED_COUNT)) counted++;
    end
  endtask

  initial begin
    item_t             directed [$];
    logic [TICK_W-1:0] one_set  [PHASES-1];
    logic [TICK_W-1:0] zero_set [PHASES-1];
    int unsigned       per_phase;

    per_phase = ITEMS_TOTAL / PHASES;
    // Both extremes for each register, one setting one step in from them, then random.
    one_set  = '{10'd1023, 10'd0, 10'd1, TICK_W'($urandom_range(0, 1023)),
                 TICK_W'($urandom_range(0, 1023))};
    zero_set = '{10'd0, 10'd1023, 10'd1022, TICK_W'($urandom_range(0, 1023)),
                 TICK_W'($urandom_range(0, 1023))};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at reset timing. A tick on an empty store, writes at the
    // first and last LED, writes past the LED count (must change nothing), then
    // ticks through the first LED while its colour is rewritten mid-transfer to
    // show colours are read live. Unused fields of the ticks before the rewrite
    // flip between all zeros and all ones.
    directed.push_back(mk(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    directed.push_back(mk(OP_SET_COLOR, 8'd0, 8'd255, 8'd0, 8'd128));
    directed.push_back(mk(OP_SET_COLOR, 8'(LED_COUNT - 1), 8'd1, 8'd254, 8'd255));
    directed.push_back(mk(OP_SET_COLOR, 8'(LED_COUNT), 8'd255, 8'd255, 8'd255));
    directed.push_back(mk(OP_SET_COLOR, 8'd255, 8'd255, 8'd255, 8'd255));
    directed.push_back(mk(OP_SET_COLOR, 8'd4, 8'd200, 8'd100, 8'd50));
    for (int i = 0; i < 8; i++)
      directed.push_back(mk(OP_TICK, i[0] ? 8'hFF : 8'h00, i[0] ? 8'hFF : 8'h00,
                            i[0] ? 8'hFF : 8'h00, i[0] ? 8'hFF : 8'h00));
    directed.push_back(mk(OP_SET_COLOR, 8'd0, 8'd0, 8'd255, 8'd0));
    for (int i = 0; i < 10; i++)
      directed.push_back(mk(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom)));
    foreach (directed[i]) begin
      idle(gap_len());
      push_item(directed[i]);
    end

    run_random(per_phase, 1'b0);

    // New timing only between phases, with the block drained.
    for (int p = 0; p < PHASES - 1; p++) begin
      settle(1'b0);
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_ONE_HIGH, one_set[p]);
        write_reg(CFG_ZERO_HIGH, zero_set[p]);
      end else begin
        write_reg(CFG_ZERO_HIGH, zero_set[p]);
        write_reg(CFG_ONE_HIGH, one_set[p]);
      end
      n_settings++;
      run_random(per_phase, p == 1);
    end

    // Release the output so any stray slot shows up before the verdict.
    settle(1'b1);
    $display("covered %0d ticks, %0d colour writes, %0d out-of-range writes, %0d timings",
             n_ticks, n_sets, n_ignored, n_settings);
    $display("%0d slots compared over %0d frame ends, with one %0d-cycle output hold",
             slots_checked, frames_checked, LONG_HOLD);
    if (fail_count == 0) begin
      $display("tb_led_strip_gamma_pulse_encoder_unit passed");
    end else begin
      $display("tb_led_strip_gamma_pulse_encoder_unit failed");
    end
    $finish;
  end

endmodule
